// ----- hw/rtl/scdec_pkg.sv -----
// ----------------------------------------------------------------------------
// scdec_pkg: shared types and tables for the scan code decoder
// Holds the decoder state and result records, the special scan bytes, the
// key indexes that steer the lookup and the two-column key map.
// ----------------------------------------------------------------------------
package scdec_pkg;

  localparam int unsigned TABLE_DEFINED = 89;

  localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
  localparam logic [7:0] BYTE_PREFIX = 8'hE0;
  localparam logic [7:0] CODE_PAUSE  = 8'hA0;
  localparam logic [7:0] CODE_NONE   = 8'h00;

  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

  localparam logic [6:0] IDX_LSHIFT    = 7'd42;
  localparam logic [6:0] IDX_RSHIFT    = 7'd54;
  localparam logic [6:0] IDX_CAPS      = 7'd58;
  localparam logic [6:0] IDX_NUM       = 7'd69;
  localparam logic [6:0] IDX_SCROLL    = 7'd70;
  localparam logic [6:0] IDX_SYM_FIRST = 7'd2;
  localparam logic [6:0] IDX_SYM_LAST  = 7'd53;
  localparam logic [6:0] IDX_PAD_FIRST = 7'd71;
  localparam logic [6:0] IDX_PAD_LAST  = 7'd83;

  typedef struct packed {
    logic       shift_held;
    logic       caps_on;
    logic       num_on;
    logic       scroll_on;
    logic       prefix_pending;
    logic [2:0] pause_bytes_left;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       pressed;
    logic       extended;
    logic       led_changed;
    logic       caps_led;
    logic       num_led;
    logic       scroll_led;
  } key_result_t;

  localparam logic [7:0] PLAIN_COL [0:TABLE_DEFINED-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A,
    8'h84, 8'h20, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A,
    8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h2D, 8'h95, 8'h96, 8'h97, 8'h2B, 8'h98,
    8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h00, 8'h00, 8'h00, 8'h9D,
    8'h9E
  };

  localparam logic [7:0] SHIFTED_COL [0:TABLE_DEFINED-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A,
    8'h84, 8'h20, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A,
    8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9D,
    8'h9E
  };

  // Entries past the defined rows read as no key.
  function automatic logic [7:0] plain_code(input logic [6:0] idx);
    logic [7:0] code;
    code = CODE_NONE;
    if (32'(idx) < TABLE_DEFINED) begin
      code = PLAIN_COL[idx];
    end
    return code;
  endfunction

  function automatic logic [7:0] shifted_code(input logic [6:0] idx);
    logic [7:0] code;
    code = CODE_NONE;
    if (32'(idx) < TABLE_DEFINED) begin
      code = SHIFTED_COL[idx];
    end
    return code;
  endfunction

endpackage

// ----- hw/rtl/scdec_decode.sv -----
// ----------------------------------------------------------------------------
// scdec_decode: single scan byte decode step
// Combinational next state and result for one scan byte against the
// current lock, prefix and pause-skip state.
// ----------------------------------------------------------------------------
module scdec_decode #(
  parameter int PAUSE_SKIP  = 2,
  parameter int MAP_ENTRIES = 89
) (
  input  logic [7:0]             scan_byte,
  input  scdec_pkg::scan_state_t state,
  output scdec_pkg::scan_state_t state_next,
  output scdec_pkg::key_result_t res,
  output logic                   res_valid
);
  import scdec_pkg::*;

  localparam logic [7:0] MAP_LIMIT  = 8'(MAP_ENTRIES);
  localparam logic [2:0] SKIP_COUNT = 3'(PAUSE_SKIP);

  logic [6:0] idx;
  logic       down;
  logic       in_map;
  logic [7:0] code_plain;
  logic [7:0] code_shifted;
  logic       is_letter;
  logic       is_symbol;
  logic       is_keypad;
  logic       use_shifted;

  assign idx  = scan_byte[6:0];
  assign down = ~scan_byte[7];

  assign in_map       = {1'b0, idx} < MAP_LIMIT;
  assign code_plain   = in_map ? plain_code(idx) : CODE_NONE;
  assign code_shifted = in_map ? shifted_code(idx) : CODE_NONE;

  always_comb begin
    is_letter = code_plain inside {[CHAR_LOW_A:CHAR_LOW_Z]};
    is_symbol = idx inside {[IDX_SYM_FIRST:IDX_SYM_LAST]};
    is_keypad = idx inside {[IDX_PAD_FIRST:IDX_PAD_LAST]};
    if (is_letter) begin
      use_shifted = state.shift_held ^ state.caps_on;
    end else if (is_symbol) begin
      use_shifted = state.shift_held;
    end else if (is_keypad && !state.prefix_pending) begin
      use_shifted = state.num_on;
    end else begin
      use_shifted = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '0;
    if (state.pause_bytes_left != 3'd0) begin
      // swallow the rest of the pause sequence
      state_next.pause_bytes_left = state.pause_bytes_left - 3'd1;
    end else if (scan_byte == BYTE_PAUSE) begin
      state_next.pause_bytes_left = SKIP_COUNT;
      res_valid       = 1'b1;
      res.key_code    = CODE_PAUSE;
      res.pressed     = 1'b1;
      res.caps_led    = state.caps_on;
      res.num_led     = state.num_on;
      res.scroll_led  = state.scroll_on;
    end else if (scan_byte == BYTE_PREFIX) begin
      state_next.prefix_pending = 1'b1;
    end else begin
      state_next.prefix_pending = 1'b0;
      res_valid    = 1'b1;
      res.key_code = use_shifted ? code_shifted : code_plain;
      res.pressed  = down;
      res.extended = state.prefix_pending;
      if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
        state_next.shift_held = down;
      end else if (idx == IDX_CAPS && down) begin
        state_next.caps_on = ~state.caps_on;
        res.led_changed    = 1'b1;
      end else if (idx == IDX_NUM && down) begin
        state_next.num_on = ~state.num_on;
        res.led_changed   = 1'b1;
      end else if (idx == IDX_SCROLL && down) begin
        state_next.scroll_on = ~state.scroll_on;
        res.led_changed      = 1'b1;
      end
      res.caps_led   = state_next.caps_on;
      res.num_led    = state_next.num_on;
      res.scroll_led = state_next.scroll_on;
    end
  end

endmodule

// ----- hw/rtl/scan_code_to_ascii_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// scan_code_to_ascii_decoder_unit: set-1 scan byte to key code decoder
// Turns raw keyboard scan bytes into key codes with press/release, extended
// and lock LED marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, scan_byte) takes one raw scan byte per
//   transfer. Output channel (out_valid/out_ready) carries one key result.
//   Prefix bytes and bytes skipped after a pause byte give no result; every
//   other byte gives exactly one.
//   A byte lands in the input register on its transfer; once the output
//   register is free, or the byte gives no result, it is decoded and the
//   result is loaded into the output register, which raises out_valid.
//   Throughput: one byte per cycle unless the receiver stalls; the table
//   lookup and lock/prefix update sit in one combinational step between
//   the two registers.
//   Reset clears the lock flags, shift, prefix and pause-skip count, and
//   empties both registers.
//   When the receiver stalls, the result holds in the output register and
//   one more byte may wait in the input register; in_ready drops only when
//   both are full and out_ready is low.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_decoder_unit #(
  parameter int PAUSE_SKIP  = 2,
  parameter int MAP_ENTRIES = 89
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] key_code,
  output logic       pressed,
  output logic       extended,
  output logic       led_changed,
  output logic       caps_led,
  output logic       num_led,
  output logic       scroll_led
);
  import scdec_pkg::*;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // decoder state
  scan_state_t state;
  scan_state_t state_next;

  // decode result and output register
  key_result_t res;
  logic        res_valid;
  key_result_t out_res;

  logic        out_free;
  logic        s1_advance;

  scdec_decode #(
    .PAUSE_SKIP  (PAUSE_SKIP),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_decode (
    .scan_byte  (s1_byte),
    .state      (state),
    .state_next (state_next),
    .res        (res),
    .res_valid  (res_valid)
  );

  // A byte without a result never waits on the output side.
  assign out_free   = ~out_valid | out_ready;
  assign s1_advance = s1_valid & (~res_valid | out_free);
  assign in_ready   = ~s1_valid | s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // hold the byte until it is decoded
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= scan_byte;
    end
  end

  // advance the state only when the decoded byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res_valid) begin
      out_res <= res;
    end
  end

  assign key_code    = out_res.key_code;
  assign pressed     = out_res.pressed;
  assign extended    = out_res.extended;
  assign led_changed = out_res.led_changed;
  assign caps_led    = out_res.caps_led;
  assign num_led     = out_res.num_led;
  assign scroll_led  = out_res.scroll_led;

`ifndef SYNTHESIS
  // a free output slot must never block the input
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output slot is free");

  // skipped pause bytes count down by one each
  a_pause_countdown: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && state.pause_bytes_left != 3'd0) |=>
      (state.pause_bytes_left == $past(state.pause_bytes_left) - 3'd1))
    else $error("pause skip count did not count down");

  // only a key press can toggle a lock
  a_led_on_press: assert property (@(posedge clk) disable iff (rst)
    (out_valid && led_changed) |-> pressed)
    else $error("LED change reported on a release");

  // a pause result is always a plain press
  a_pause_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_code == CODE_PAUSE) |-> (pressed && !extended && !led_changed))
    else $error("pause result carries wrong marks");
`endif

endmodule
